// ===== design/breakpoint_table_engine_defines.svh =====
// Assertion helpers used by the breakpoint table sequencer (bte_seq).
`ifndef BREAKPOINT_TABLE_ENGINE_DEFINES_SVH
`define BREAKPOINT_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BTE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define BTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bte_pkg.sv =====
package bte_pkg;

  // Command codes
  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_ENABLE  = 3'd2;
  localparam logic [2:0] OP_DISABLE = 3'd3;
  localparam logic [2:0] OP_TRAP    = 3'd4;
  localparam logic [2:0] OP_LIST    = 3'd5;
  localparam logic [2:0] OP_CLEAR   = 3'd6;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_STATE    = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_CONFLICT = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_ARG      = 3'd5;

  localparam logic [7:0] TRAP_BYTE   = 8'hCC;
  localparam int         MAX_RESULTS = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_ACT,
    S_FIN
  } seq_state_t;

  // One command beat
  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] address;
    logic [31:0] bp_id;
    logic [4:0]  start_index;
    logic [4:0]  max_entries;
    logic [7:0]  read_byte;
    logic        memory_ok;
    logic        target_stopped;
  } cmd_t;

  // One table slot
  typedef struct packed {
    logic [31:0] id;
    logic        enabled;
    logic [7:0]  saved_byte;
    logic [63:0] address;
    logic [31:0] hits;
  } entry_t;

  // One result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] entry_id;
    logic [63:0] entry_address;
    logic [7:0]  saved_byte;
    logic        entry_enabled;
    logic [31:0] hits;
    logic [4:0]  total_entries;
    logic        consumed;
    logic        last;
  } result_t;

  // Table write controls
  typedef struct packed {
    logic we;
    logic set_valid;
    logic clr_valid;
    logic clr_all;
  } wr_ctl_t;

endpackage

// ===== design/breakpoint_table_engine.sv =====
// Breakpoint table: keeps ENTRIES software breakpoints in a slot memory and
// runs one command at a time (add, remove, enable, disable, trap hit, list
// page, clear all). A command is taken only while the engine is idle; it is
// answered after a scan of the slot memory (each free slot is skipped, each
// used slot is read through a registered read, then compared) and a final
// step to commit and answer. No scan is needed when the target is not
// stopped, for identifier 0, program counter 0, a bad or empty list page, an
// unknown opcode, or list page or clear all on an empty table; otherwise add,
// trap hit, remove, enable and disable scan, even on an empty table. List page
// and clear all send one beat per reported slot during the scan, so a
// stalled result side slows the scan. Results leave through an output
// register.
module breakpoint_table_engine #(
  parameter int ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // address[63:0], bp_id[95:64], start_index[100:96], max_entries[105:101],
  // read_byte[113:106], memory_ok[114], target_stopped[115], zero[119:116]
  input  logic [119:0] s_tdata,
  // opcode[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // entry_id[31:0], entry_address[95:32], saved_byte[103:96],
  // entry_enabled[104], hits[136:105], total_entries[141:137],
  // consumed[142], zero[143]
  output logic [143:0] m_tdata,
  // status[2:0]
  output logic [2:0]   m_tuser,
  output logic         m_tlast
);

  localparam int IW = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

  bte_pkg::cmd_t     cmd;
  bte_pkg::result_t  res, out_q;
  logic              res_valid, res_ready;
  logic [IW-1:0]     raddr, waddr;
  bte_pkg::entry_t   rdata, wdata;
  bte_pkg::wr_ctl_t  wr;
  logic [ENTRIES-1:0] valid;

  // Unpack the command beat
  always_comb begin
    cmd.opcode         = s_tuser;
    cmd.address        = s_tdata[63:0];
    cmd.bp_id          = s_tdata[95:64];
    cmd.start_index    = s_tdata[100:96];
    cmd.max_entries    = s_tdata[105:101];
    cmd.read_byte      = s_tdata[113:106];
    cmd.memory_ok      = s_tdata[114];
    cmd.target_stopped = s_tdata[115];
  end

  bte_mem #(
    .ENTRIES (ENTRIES)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .raddr (raddr),
    .rdata (rdata),
    .waddr (waddr),
    .wdata (wdata),
    .wr    (wr),
    .valid (valid)
  );

  bte_seq #(
    .ENTRIES (ENTRIES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .raddr     (raddr),
    .rdata     (rdata),
    .waddr     (waddr),
    .wdata     (wdata),
    .wr        (wr),
    .valid     (valid)
  );

  // Output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  // Pack the result beat
  assign m_tdata = {1'b0, out_q.consumed, out_q.total_entries, out_q.hits,
                    out_q.entry_enabled, out_q.saved_byte, out_q.entry_address,
                    out_q.entry_id};
  assign m_tuser = out_q.status;
  assign m_tlast = out_q.last;

endmodule

// ===== design/bte_mem.sv =====
module bte_mem #(
  parameter int ENTRIES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] raddr,
  output bte_pkg::entry_t                      rdata,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] waddr,
  input  bte_pkg::entry_t                      wdata,
  input  bte_pkg::wr_ctl_t                     wr,
  output logic [ENTRIES-1:0]                   valid
);

  bte_pkg::entry_t mem [ENTRIES];
  bte_pkg::entry_t rd_q;
  logic            rd_valid;

  // Slot storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // Per-slot in-use bits; a free slot reads as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[raddr];
      if (wr.clr_all) begin
        valid <= '0;
      end else begin
        if (wr.set_valid) valid[waddr] <= 1'b1;
        if (wr.clr_valid) valid[waddr] <= 1'b0;
      end
    end
  end

  assign rdata = rd_valid ? rd_q : '0;

endmodule

// ===== design/bte_seq.sv =====
`include "breakpoint_table_engine_defines.svh"

module bte_seq #(
  parameter int ENTRIES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  bte_pkg::cmd_t                        cmd,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output bte_pkg::result_t                     res,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] raddr,
  input  bte_pkg::entry_t                      rdata,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] waddr,
  output bte_pkg::entry_t                      wdata,
  output bte_pkg::wr_ctl_t                     wr,
  input  logic [ENTRIES-1:0]                   valid
);

  localparam int IW = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int UW = $clog2(ENTRIES + 1);
  localparam int CW = UW > 5 ? UW : 5;

  bte_pkg::seq_state_t state, state_next;
  bte_pkg::cmd_t       cmd_q;
  logic [63:0]         target;
  logic [IW-1:0]       idx, idx_next;
  logic [UW-1:0]       logical, logical_next;
  logic [4:0]          n, n_next;
  logic                dup, dup_next;
  logic [2:0]          fin_st, fin_st_next;
  logic [UW-1:0]       used, used_next;
  logic [31:0]         next_id, nid_next, nid_inc;
  logic                imm;
  logic [2:0]          imm_st;
  logic                has_free;
  logic [IW-1:0]       free_slot;
  logic                more_above;
  logic                emit_last;
  logic [4:0]          cap_in, cap_q;
  bte_pkg::entry_t     e;

  function automatic logic [4:0] cap_of(input logic [4:0] m);
    return (m > 5'(bte_pkg::MAX_RESULTS)) ? 5'(bte_pkg::MAX_RESULTS) : m;
  endfunction

  function automatic bte_pkg::result_t none_res(input logic [2:0] st, input logic [4:0] tot);
    bte_pkg::result_t r;
    r               = '0;
    r.status        = st;
    r.total_entries = tot;
    r.last          = 1'b1;
    return r;
  endfunction

  function automatic bte_pkg::result_t slot_res(input bte_pkg::entry_t s, input logic [2:0] st,
                                                input logic [4:0] tot, input logic cons,
                                                input logic lst);
    bte_pkg::result_t r;
    r.status        = st;
    r.entry_id      = s.id;
    r.entry_address = s.address;
    r.saved_byte    = s.saved_byte;
    r.entry_enabled = s.enabled;
    r.hits          = s.hits;
    r.total_entries = tot;
    r.consumed      = cons;
    r.last          = lst;
    return r;
  endfunction

  assign raddr   = idx;
  assign e       = rdata;
  assign cap_in  = cap_of(cmd.max_entries);
  assign cap_q   = cap_of(cmd_q.max_entries);
  assign nid_inc = next_id + 32'd1;
  assign waddr   = (state == bte_pkg::S_FIN) ? free_slot : idx;

  // Lowest free slot
  always_comb begin
    has_free  = 1'b0;
    free_slot = '0;
    for (int j = ENTRIES - 1; j >= 0; j--) begin
      if (!valid[j]) begin
        has_free  = 1'b1;
        free_slot = IW'(j);
      end
    end
  end

  // Any used slot after the current one
  always_comb begin
    more_above = 1'b0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (valid[j] && (j > int'(idx))) more_above = 1'b1;
    end
  end

  // Commands answered without a table scan
  always_comb begin
    imm    = 1'b1;
    imm_st = bte_pkg::ST_OK;
    unique case (cmd.opcode)
      bte_pkg::OP_ADD: begin
        if (!cmd.target_stopped) imm_st = bte_pkg::ST_STATE;
        else imm = 1'b0;
      end
      bte_pkg::OP_REMOVE, bte_pkg::OP_ENABLE, bte_pkg::OP_DISABLE: begin
        if (!cmd.target_stopped) imm_st = bte_pkg::ST_STATE;
        else if (cmd.bp_id == 32'd0) imm_st = bte_pkg::ST_NOTFOUND;
        else imm = 1'b0;
      end
      bte_pkg::OP_TRAP: begin
        if (cmd.address != 64'd0) imm = 1'b0;
      end
      bte_pkg::OP_LIST: begin
        if (CW'(cmd.start_index) > CW'(used)) imm_st = bte_pkg::ST_ARG;
        else if (cap_in != 5'd0 && CW'(cmd.start_index) != CW'(used)) imm = 1'b0;
      end
      bte_pkg::OP_CLEAR: begin
        if (!cmd.target_stopped) imm_st = bte_pkg::ST_STATE;
        else if (used != '0) imm = 1'b0;
      end
      default: imm_st = bte_pkg::ST_ARG;
    endcase
  end

  // State register and command capture
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bte_pkg::S_IDLE;
      idx     <= '0;
      logical <= '0;
      n       <= '0;
      dup     <= 1'b0;
      fin_st  <= bte_pkg::ST_OK;
      used    <= '0;
      next_id <= 32'd1;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      logical <= logical_next;
      n       <= n_next;
      dup     <= dup_next;
      fin_st  <= fin_st_next;
      used    <= used_next;
      next_id <= nid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q  <= cmd;
      target <= cmd.address - 64'd1;
    end
  end

  // Sequencer: scan slots, then answer and write back
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    logical_next = logical;
    n_next       = n;
    dup_next     = dup;
    fin_st_next  = fin_st;
    used_next    = used;
    nid_next     = next_id;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    res          = none_res(fin_st, 5'(used));
    wr           = '0;
    wdata        = e;
    emit_last    = 1'b0;

    unique case (state)
      bte_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          idx_next     = '0;
          logical_next = '0;
          n_next       = '0;
          dup_next     = 1'b0;
          fin_st_next  = imm_st;
          state_next   = imm ? bte_pkg::S_FIN : bte_pkg::S_RD;
        end
      end

      bte_pkg::S_RD: begin
        if (valid[idx]) begin
          state_next = bte_pkg::S_EV;
        end else if (idx == IW'(ENTRIES - 1)) begin
          state_next  = bte_pkg::S_FIN;
          fin_st_next = (cmd_q.opcode == bte_pkg::OP_TRAP) ? bte_pkg::ST_OK
                                                           : bte_pkg::ST_NOTFOUND;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = bte_pkg::S_RD;
        end
      end

      bte_pkg::S_EV: begin
        priority if (cmd_q.opcode == bte_pkg::OP_ADD && e.address == cmd_q.address) begin
          dup_next   = 1'b1;
          state_next = bte_pkg::S_FIN;
        end else if ((cmd_q.opcode == bte_pkg::OP_REMOVE || cmd_q.opcode == bte_pkg::OP_ENABLE ||
                      cmd_q.opcode == bte_pkg::OP_DISABLE) && e.id == cmd_q.bp_id) begin
          state_next = bte_pkg::S_ACT;
        end else if (cmd_q.opcode == bte_pkg::OP_TRAP && e.enabled && e.address == target) begin
          state_next = bte_pkg::S_ACT;
        end else if (cmd_q.opcode == bte_pkg::OP_LIST &&
                     CW'(logical) >= CW'(cmd_q.start_index)) begin
          emit_last = !more_above || (n + 5'd1 == cap_q);
          res_valid = 1'b1;
          res       = slot_res(e, bte_pkg::ST_OK, 5'(used), 1'b0, emit_last);
          if (res_ready) begin
            n_next       = n + 5'd1;
            logical_next = logical + UW'(1);
            state_next   = bte_pkg::S_RD;
            idx_next     = idx + IW'(1);
            if (emit_last) state_next = bte_pkg::S_IDLE;
          end
        end else if (cmd_q.opcode == bte_pkg::OP_CLEAR) begin
          emit_last = !more_above || (n == 5'(bte_pkg::MAX_RESULTS - 1));
          res_valid = 1'b1;
          res       = slot_res(e, (e.enabled && !cmd_q.memory_ok) ? bte_pkg::ST_CONFLICT
                                                                : bte_pkg::ST_OK,
                               5'd0, 1'b0, emit_last);
          if (res_ready) begin
            n_next     = n + 5'd1;
            state_next = bte_pkg::S_RD;
            idx_next   = idx + IW'(1);
            if (emit_last) begin
              wr.clr_all = 1'b1;
              used_next  = '0;
              state_next = bte_pkg::S_IDLE;
            end
          end
        end else begin
          // no match here: step on, or end the scan
          if (cmd_q.opcode == bte_pkg::OP_LIST) logical_next = logical + UW'(1);
          if (idx == IW'(ENTRIES - 1)) begin
            state_next  = bte_pkg::S_FIN;
            fin_st_next = (cmd_q.opcode == bte_pkg::OP_TRAP) ? bte_pkg::ST_OK
                                                             : bte_pkg::ST_NOTFOUND;
          end else begin
            idx_next   = idx + IW'(1);
            state_next = bte_pkg::S_RD;
          end
        end
      end

      bte_pkg::S_ACT: begin
        // slot idx matched; read data still held
        res_valid = 1'b1;
        unique case (cmd_q.opcode)
          bte_pkg::OP_REMOVE: begin
            if (e.enabled && !cmd_q.memory_ok) begin
              res = none_res(bte_pkg::ST_CONFLICT, 5'(used));
            end else begin
              wdata.enabled = 1'b0;
              res = slot_res(wdata, bte_pkg::ST_OK, 5'(used - UW'(1)), 1'b0, 1'b1);
              if (res_ready) begin
                wr.clr_valid = 1'b1;
                used_next    = used - UW'(1);
              end
            end
          end
          bte_pkg::OP_DISABLE: begin
            if (e.enabled && !cmd_q.memory_ok) begin
              res = none_res(bte_pkg::ST_CONFLICT, 5'(used));
            end else begin
              wdata.enabled = 1'b0;
              res   = slot_res(wdata, bte_pkg::ST_OK, 5'(used), 1'b0, 1'b1);
              wr.we = res_ready;
            end
          end
          bte_pkg::OP_ENABLE: begin
            if (!e.enabled && !cmd_q.memory_ok) begin
              res = none_res(bte_pkg::ST_CONFLICT, 5'(used));
            end else begin
              wdata.enabled = 1'b1;
              res   = slot_res(wdata, bte_pkg::ST_OK, 5'(used), 1'b0, 1'b1);
              wr.we = res_ready;
            end
          end
          default: begin
            // trap hit: saturating count
            wdata.hits = (e.hits == 32'hFFFF_FFFF) ? e.hits : e.hits + 32'd1;
            res   = slot_res(wdata, bte_pkg::ST_OK, 5'(used), 1'b1, 1'b1);
            wr.we = res_ready;
          end
        endcase
        if (res_ready) state_next = bte_pkg::S_IDLE;
      end

      default: begin
        // S_FIN: single answer, add commits here
        res_valid = 1'b1;
        if (cmd_q.opcode == bte_pkg::OP_ADD && cmd_q.target_stopped) begin
          priority if (dup) begin
            res = none_res(bte_pkg::ST_CONFLICT, 5'(used));
          end else if (!has_free) begin
            res = none_res(bte_pkg::ST_FULL, 5'(used));
          end else if (!cmd_q.memory_ok || cmd_q.read_byte == bte_pkg::TRAP_BYTE) begin
            res = none_res(bte_pkg::ST_CONFLICT, 5'(used));
          end else begin
            wdata.id         = next_id;
            wdata.enabled    = 1'b1;
            wdata.saved_byte = cmd_q.read_byte;
            wdata.address    = cmd_q.address;
            wdata.hits       = 32'd0;
            res = slot_res(wdata, bte_pkg::ST_OK, 5'(used + UW'(1)), 1'b0, 1'b1);
            if (res_ready) begin
              wr.we        = 1'b1;
              wr.set_valid = 1'b1;
              used_next    = used + UW'(1);
              nid_next     = (nid_inc == 32'd0) ? 32'd1 : nid_inc;
            end
          end
        end
        if (res_ready) state_next = bte_pkg::S_IDLE;
      end
    endcase
  end

  `BTE_ASSERT_NOW(a_write_in_commit, clk, rst, wr.we || wr.set_valid || wr.clr_valid, state == bte_pkg::S_ACT || state == bte_pkg::S_FIN, "table write outside a commit state")
  `BTE_ASSERT_NOW(a_count_tracks, clk, rst, 1'b1, $countones(valid) == used, "used count differs from slots in use")
  `BTE_ASSERT_NEXT(a_clear_empties, clk, rst, wr.clr_all, valid == '0 && used == '0, "clear all left slots in use")
  `BTE_ASSERT_NOW(a_idle_quiet, clk, rst, state == bte_pkg::S_IDLE, !res_valid && !wr.we, "result or write while idle")

endmodule

// ===== tb/breakpoint_table_engine_tb.sv =====
module breakpoint_table_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode outside the command set
  localparam logic [2:0] OP_UNDEF = 3'd7;

  localparam int RANDOM_ITEMS = 345;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 3000;
  localparam int SLOTS        = 16;

  // One directed command; typed rows carry a single no-entry result
  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] addr;
    logic [31:0] id;
    logic [4:0]  start;
    logic [4:0]  maxe;
    logic [7:0]  rb;
    logic        mok;
    logic        stop;
    logic        typed;
    logic [2:0]  st;
    logic [4:0]  tot;
  } row_t;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  row_t directed_rows [27] = '{
    // empty table: list, clear, add while running
    '{bte_pkg::OP_LIST, '0, '0, 5'd0, 5'd16, 8'h00, 1'b1, 1'b1, 1'b1, bte_pkg::ST_OK, 5'd0},
    '{bte_pkg::OP_CLEAR, '0, '0, 5'd0, 5'd0, 8'h00, 1'b1, 1'b1, 1'b1, bte_pkg::ST_OK, 5'd0},
    '{bte_pkg::OP_ADD, 64'h1000, '0, 5'd0, 5'd0, 8'h10, 1'b1, 1'b0, 1'b1,
      bte_pkg::ST_STATE, 5'd0},
    // plant at the address extremes
    '{bte_pkg::OP_ADD, '0, '0, 5'd0, 5'd0, 8'h00, 1'b1, 1'b1, 1'b0, bte_pkg::ST_OK, 5'd0},
    '{bte_pkg::OP_ADD, ALL_ONES, '0, 5'd0, 5'd0, 8'hFF, 1'b1, 1'b1, 1'b0,
      bte_pkg::ST_OK, 5'd0},
    // duplicate, trap byte, failed read
    '{bte_pkg::OP_ADD, '0, '0, 5'd0, 5'd0, 8'h12, 1'b1, 1'b1, 1'b1,
      bte_pkg::ST_CONFLICT, 5'd2},
    '{bte_pkg::OP_ADD, 64'h2000, '0, 5'd0, 5'd0, bte_pkg::TRAP_BYTE, 1'b1, 1'b1, 1'b1,
      bte_pkg::ST_CONFLICT, 5'd2},
    '{bte_pkg::OP_ADD, 64'h3000, '0, 5'd0, 5'd0, 8'h55, 1'b0, 1'b1, 1'b1,
      bte_pkg::ST_CONFLICT, 5'd2},
    // identifier zero, unknown identifier, disable while running
    '{bte_pkg::OP_REMOVE, '0, '0, 5'd0, 5'd0, 8'h00, 1'b1, 1'b1, 1'b1,
      bte_pkg::ST_NOTFOUND, 5'd2},
    '{bte_pkg::OP_ENABLE, '0, 32'hFFFF_FFFF, 5'd0, 5'd0, 8'h00, 1'b1, 1'b1, 1'b1,
      bte_pkg::ST_NOTFOUND, 5'd2},
    '{bte_pkg::OP_DISABLE, '0, 32'd1, 5'd0, 5'd0, 8'h00, 1'b1, 1'b0, 1'b1,
      bte_pkg::ST_STATE, 5'd2},
    // trap at pc 0, hit on the entry at 0, miss at the top of memory
    '{bte_pkg::OP_TRAP, '0, '0, 5'd0, 5'd0, 8'h00, 1'b1, 1'b0, 1'b1, bte_pkg::ST_OK, 5'd2},
    '{bte_pkg::OP_TRAP, 64'd1, '0, 5'd0, 5'd0, 8'h00, 1'b1, 1'b1, 1'b0, bte_pkg::ST_OK, 5'd0},
    '{bte_pkg::OP_TRAP, ALL_ONES, '0, 5'd0, 5'd0, 8'h00, 1'b1, 1'b1, 1'b1,
      bte_pkg::ST_OK, 5'd2},
    // patch failures and no-patch toggles
    '{bte_pkg::OP_DISABLE, '0, 32'd1, 5'd0, 5'd0, 8'h00, 1'b0, 1'b1, 1'b1,
      bte_pkg::ST_CONFLICT, 5'd2},
    '{bte_pkg::OP_DISABLE, '0, 32'd1, 5'd0, 5'd0, 8'h00, 1'b1, 1'b1, 1'b0,
      bte_pkg::ST_OK, 5'd0},
    '{bte_pkg::OP_DISABLE, '0, 32'd1, 5'd0, 5'd0, 8'h00, 1'b0, 1'b1, 1'b0,
      bte_pkg::ST_OK, 5'd0},
    '{bte_pkg::OP_ENABLE, '0, 32'd1, 5'd0, 5'd0, 8'h00, 1'b0, 1'b1, 1'b1,
      bte_pkg::ST_CONFLICT, 5'd2},
    '{bte_pkg::OP_TRAP, 64'd1, '0, 5'd0, 5'd0, 8'h00, 1'b1, 1'b1, 1'b1, bte_pkg::ST_OK, 5'd2},
    '{bte_pkg::OP_ENABLE, '0, 32'd1, 5'd0, 5'd0, 8'h00, 1'b1, 1'b1, 1'b0,
      bte_pkg::ST_OK, 5'd0},
    // paging: bad start, empty page, zero size, oversize; then a failed remove and an unknown opcode
    '{bte_pkg::OP_LIST, '0, '0, 5'd3, 5'd16, 8'h00, 1'b1, 1'b1, 1'b1, bte_pkg::ST_ARG, 5'd2},
    '{bte_pkg::OP_LIST, '0, '0, 5'd2, 5'd16, 8'h00, 1'b1, 1'b1, 1'b1, bte_pkg::ST_OK, 5'd2},
    '{bte_pkg::OP_LIST, '0, '0, 5'd0, 5'd0, 8'h00, 1'b1, 1'b1, 1'b1, bte_pkg::ST_OK, 5'd2},
    '{bte_pkg::OP_LIST, '0, '0, 5'd0, 5'd31, 8'h00, 1'b1, 1'b0, 1'b0, bte_pkg::ST_OK, 5'd0},
    '{bte_pkg::OP_REMOVE, '0, 32'd2, 5'd0, 5'd0, 8'h00, 1'b0, 1'b1, 1'b1,
      bte_pkg::ST_CONFLICT, 5'd2},
    '{OP_UNDEF, '0, '0, 5'd0, 5'd0, 8'h00, 1'b1, 1'b1, 1'b1, bte_pkg::ST_ARG, 5'd2},
    // clear with failing restores
    '{bte_pkg::OP_CLEAR, '0, '0, 5'd0, 5'd0, 8'h00, 1'b0, 1'b1, 1'b0, bte_pkg::ST_OK, 5'd0}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;

  // Predicted table state
  bte_pkg::entry_t bp_table [SLOTS] = '{default: '0};
  int              used_count = 0;
  logic [31:0]     next_bp_id = 32'd1;

  bte_pkg::result_t new_results[$];
  bte_pkg::result_t pending_results[$];

  int               errors = 0;
  int               snd_idle_pct = 0;
  int               rcv_idle_pct = 0;
  bit               hold_req = 1'b0;
  bit               use_fixed = 1'b0;
  bte_pkg::result_t fixed_result = '0;

  breakpoint_table_engine DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bte_pkg::result_t bare_result(logic [2:0] st);
    bte_pkg::result_t r;
    r = '0;
    r.status = st;
    r.total_entries = 5'(used_count);
    return r;
  endfunction

  function automatic bte_pkg::result_t slot_result(logic [2:0] st, int s, int tot, logic cons);
    bte_pkg::result_t r;
    r = '0;
    r.status = st;
    r.entry_id = bp_table[s].id;
    r.entry_address = bp_table[s].address;
    r.saved_byte = bp_table[s].saved_byte;
    r.entry_enabled = bp_table[s].enabled;
    r.hits = bp_table[s].hits;
    r.total_entries = 5'(tot);
    r.consumed = cons;
    return r;
  endfunction

  // Apply one command to the predicted table and build its result beats
  task automatic compute_results(input bte_pkg::cmd_t c);
    int               slot;
    int               listed;
    int               cap;
    logic             dup;
    bte_pkg::result_t gone;
    new_results.delete();
    slot = -1;
    case (c.opcode)
      bte_pkg::OP_ADD: begin
        dup = 1'b0;
        foreach (bp_table[i])
          if (bp_table[i].id != 0 && bp_table[i].address == c.address) dup = 1'b1;
        foreach (bp_table[i])
          if (slot < 0 && bp_table[i].id == 0) slot = i;
        if (!c.target_stopped) begin
          new_results.push_back(bare_result(bte_pkg::ST_STATE));
        end else if (dup) begin
          new_results.push_back(bare_result(bte_pkg::ST_CONFLICT));
        end else if (slot < 0) begin
          new_results.push_back(bare_result(bte_pkg::ST_FULL));
        end else if (!c.memory_ok || c.read_byte == bte_pkg::TRAP_BYTE) begin
          new_results.push_back(bare_result(bte_pkg::ST_CONFLICT));
        end else begin
          bp_table[slot] = '{id: next_bp_id, enabled: 1'b1, saved_byte: c.read_byte,
                             address: c.address, hits: '0};
          next_bp_id++;
          if (next_bp_id == 0) next_bp_id = 32'd1;
          used_count++;
          new_results.push_back(slot_result(bte_pkg::ST_OK, slot, used_count, 1'b0));
        end
      end
      bte_pkg::OP_REMOVE, bte_pkg::OP_ENABLE, bte_pkg::OP_DISABLE: begin
        // lowest slot with a matching id; id 0 never matches
        if (c.bp_id != 0)
          foreach (bp_table[i])
            if (slot < 0 && bp_table[i].id == c.bp_id) slot = i;
        if (!c.target_stopped) begin
          new_results.push_back(bare_result(bte_pkg::ST_STATE));
        end else if (slot < 0) begin
          new_results.push_back(bare_result(bte_pkg::ST_NOTFOUND));
        end else if (!c.memory_ok &&
                     ((c.opcode == bte_pkg::OP_ENABLE) != bp_table[slot].enabled)) begin
          // a patch was needed and failed
          new_results.push_back(bare_result(bte_pkg::ST_CONFLICT));
        end else if (c.opcode == bte_pkg::OP_REMOVE) begin
          gone = slot_result(bte_pkg::ST_OK, slot, used_count - 1, 1'b0);
          gone.entry_enabled = 1'b0;
          bp_table[slot] = '0;
          used_count--;
          new_results.push_back(gone);
        end else begin
          bp_table[slot].enabled = (c.opcode == bte_pkg::OP_ENABLE);
          new_results.push_back(slot_result(bte_pkg::ST_OK, slot, used_count, 1'b0));
        end
      end
      bte_pkg::OP_TRAP: begin
        if (c.address != 0)
          foreach (bp_table[i])
            if (slot < 0 && bp_table[i].id != 0 && bp_table[i].enabled &&
                bp_table[i].address == c.address - 64'd1) slot = i;
        if (slot < 0) begin
          new_results.push_back(bare_result(bte_pkg::ST_OK));
        end else begin
          if (bp_table[slot].hits != 32'hFFFF_FFFF) bp_table[slot].hits++;
          new_results.push_back(slot_result(bte_pkg::ST_OK, slot, used_count, 1'b1));
        end
      end
      bte_pkg::OP_LIST: begin
        if (c.start_index > used_count) begin
          new_results.push_back(bare_result(bte_pkg::ST_ARG));
        end else begin
          cap = (int'(c.max_entries) < bte_pkg::MAX_RESULTS) ? int'(c.max_entries)
                                                              : bte_pkg::MAX_RESULTS;
          listed = 0;
          foreach (bp_table[i])
            if (bp_table[i].id != 0 && new_results.size() < cap) begin
              if (listed >= c.start_index)
                new_results.push_back(slot_result(bte_pkg::ST_OK, i, used_count, 1'b0));
              listed++;
            end
          if (new_results.size() == 0) new_results.push_back(bare_result(bte_pkg::ST_OK));
        end
      end
      bte_pkg::OP_CLEAR: begin
        if (!c.target_stopped) begin
          new_results.push_back(bare_result(bte_pkg::ST_STATE));
        end else begin
          foreach (bp_table[i])
            if (bp_table[i].id != 0) begin
              if (new_results.size() < bte_pkg::MAX_RESULTS)
                new_results.push_back(slot_result(
                  (bp_table[i].enabled && !c.memory_ok) ? bte_pkg::ST_CONFLICT
                                                        : bte_pkg::ST_OK, i, 0, 1'b0));
              bp_table[i] = '0;
            end
          used_count = 0;
          if (new_results.size() == 0) new_results.push_back(bare_result(bte_pkg::ST_OK));
        end
      end
      default: begin
        new_results.push_back(bare_result(bte_pkg::ST_ARG));
      end
    endcase
    new_results[new_results.size() - 1].last = 1'b1;
  endtask

  function automatic int pick_used_slot();
    int idx[$];
    foreach (bp_table[i])
      if (bp_table[i].id != 0) idx.push_back(i);
    if (idx.size() == 0) return -1;
    return idx[$urandom_range(0, idx.size() - 1)];
  endfunction

  // Mostly well-formed commands aimed at live entries, plus a little noise
  function automatic bte_pkg::cmd_t random_command();
    bte_pkg::cmd_t c;
    int            r;
    int            p;
    int            s;
    r = $urandom_range(0, 99);
    p = $urandom_range(0, 99);
    s = pick_used_slot();
    c.address = {$urandom, $urandom};
    c.bp_id = $urandom;
    c.start_index = 5'($urandom_range(0, 31));
    c.max_entries = 5'($urandom_range(0, 31));
    c.read_byte = ($urandom_range(0, 9) == 0) ? bte_pkg::TRAP_BYTE
                                              : 8'($urandom_range(0, 255));
    c.memory_ok = ($urandom_range(0, 99) < 88);
    c.target_stopped = ($urandom_range(0, 99) < 93);
    if (r < 32) begin
      c.opcode = bte_pkg::OP_ADD;
      if (s >= 0 && p < 35) c.address = bp_table[s].address;
      else if (p < 65) c.address = 64'($urandom_range(0, 15));
    end else if (r < 56) begin
      c.opcode = (r < 40) ? bte_pkg::OP_REMOVE :
                 (r < 48) ? bte_pkg::OP_ENABLE : bte_pkg::OP_DISABLE;
      if (s >= 0 && p < 80) c.bp_id = bp_table[s].id;
      else if (p < 88) c.bp_id = '0;
    end else if (r < 76) begin
      c.opcode = bte_pkg::OP_TRAP;
      if (s >= 0 && p < 70) c.address = bp_table[s].address + 64'd1;
      else if (p < 80) c.address = 64'($urandom_range(0, 16));
    end else if (r < 92) begin
      c.opcode = bte_pkg::OP_LIST;
      if (p < 85) c.start_index = 5'($urandom_range(0, used_count + 1));
    end else if (r < 94) begin
      c.opcode = bte_pkg::OP_CLEAR;
    end else if (r < 96) begin
      c.opcode = OP_UNDEF;
    end else begin
      // noise: anything the fields allow
      c.opcode = 3'($urandom_range(0, 7));
      c.memory_ok = 1'($urandom_range(0, 1));
      c.target_stopped = 1'($urandom_range(0, 1));
    end
    return c;
  endfunction

  // Offer one command beat, called at a falling edge; returns at its acceptance
  task automatic issue(input bte_pkg::cmd_t c, input bit typed,
                       input bte_pkg::result_t typed_res);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c.opcode;
    s_tdata <= {4'b0, c.target_stopped, c.memory_ok, c.read_byte, c.max_entries,
                c.start_index, c.bp_id, c.address};
    use_fixed = typed;
    fixed_result = typed_res;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic string show(bte_pkg::result_t r);
    return $sformatf("st=%0d id=%h addr=%h byte=%h en=%b hits=%h tot=%0d cons=%b last=%b",
                     r.status, r.entry_id, r.entry_address, r.saved_byte, r.entry_enabled,
                     r.hits, r.total_entries, r.consumed, r.last);
  endfunction

  task automatic report_failure(string what, bte_pkg::result_t want, bte_pkg::result_t got);
    errors++;
    if (errors <= 10)
      $display("ERROR @%0t %s\n  want %s\n  got  %s", $time, what, show(want), show(got));
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Predict on each accepted command beat, check each accepted result beat
  always @(posedge clk) begin
    bte_pkg::cmd_t    c;
    bte_pkg::result_t got;
    bte_pkg::result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        c.opcode = s_tuser;
        c.address = s_tdata[63:0];
        c.bp_id = s_tdata[95:64];
        c.start_index = s_tdata[100:96];
        c.max_entries = s_tdata[105:101];
        c.read_byte = s_tdata[113:106];
        c.memory_ok = s_tdata[114];
        c.target_stopped = s_tdata[115];
        compute_results(c);
        if (use_fixed) pending_results.push_back(fixed_result);
        else foreach (new_results[k]) pending_results.push_back(new_results[k]);
      end
      if (m_tvalid && m_tready) begin
        got.status = m_tuser;
        got.entry_id = m_tdata[31:0];
        got.entry_address = m_tdata[95:32];
        got.saved_byte = m_tdata[103:96];
        got.entry_enabled = m_tdata[104];
        got.hits = m_tdata[136:105];
        got.total_entries = m_tdata[141:137];
        got.consumed = m_tdata[142];
        got.last = m_tlast;
        if (pending_results.size() == 0) begin
          report_failure("result beat with nothing expected", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (want !== got) report_failure("result beat mismatch", want, got);
        end
      end
    end
  end

  // Watchdog: too long without any beat on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    bte_pkg::cmd_t    c;
    bte_pkg::result_t typed_res;
    row_t             row;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    snd_idle_pct = 17;
    rcv_idle_pct = 57;

    // directed table
    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      @(negedge clk);
      c.opcode = row.op;
      c.address = row.addr;
      c.bp_id = row.id;
      c.start_index = row.start;
      c.max_entries = row.maxe;
      c.read_byte = row.rb;
      c.memory_ok = row.mok;
      c.target_stopped = row.stop;
      typed_res = '0;
      typed_res.status = row.st;
      typed_res.total_entries = row.tot;
      typed_res.last = 1'b1;
      issue(c, row.typed, typed_res);
    end

    // random phases: slow receiver, slow sender, then full rate with one hold-off
    for (int phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 57 : 0;
      rcv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 17 : 0;
      if (phase == 2) hold_req = 1'b1;
      for (int k = 0; k < RANDOM_ITEMS / 3; k++) begin
        @(negedge clk);
        c = random_command();
        issue(c, 1'b0, '0);
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    // drain, then give the engine time to show any stray beat
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
